### hw/rtl/mlr_pkg.sv
package mlr_pkg;

	localparam int PIX_W     = 12;
	localparam int CFG_W     = 10;
	localparam int CFG_IDX_W = 2;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_STEP = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_GRID_MAX_COL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_MAX_ROW = 2'd1;

	localparam logic [CFG_W-1:0] GRID_MAX_RESET = 10'd15;

	// per-job control between front and back
	typedef struct packed {
		logic many;
		logic done;
	} job_ctl_t;

	localparam int JOB_CTL_W = $bits(job_ctl_t);

endpackage

### hw/rtl/mlr_if.sv
interface mlr_req_if #(
	parameter int COORD_BITS = 10
);
	logic                  valid;
	logic                  ready;
	logic                  req_type;
	logic [COORD_BITS-1:0] first_x;
	logic [COORD_BITS-1:0] first_y;
	logic [COORD_BITS-1:0] second_x;
	logic [COORD_BITS-1:0] second_y;
	logic                  outline;

	modport source (output valid, req_type, first_x, first_y, second_x, second_y, outline,
		input ready);
	modport sink (input valid, req_type, first_x, first_y, second_x, second_y, outline,
		output ready);
endinterface

interface mlr_pix_if;
	import mlr_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [PIX_W-1:0] pix_x;
	logic signed [PIX_W-1:0] pix_y;
	logic                    in_grid;
	logic                    last_of_item;
	logic                    line_done;

	modport source (output valid, pix_x, pix_y, in_grid, last_of_item, line_done,
		input ready);
	modport sink (input valid, pix_x, pix_y, in_grid, last_of_item, line_done,
		output ready);
endinterface

interface mlr_cfg_if;
	import mlr_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/midpoint_line_rasterizer.sv
// Midpoint line rasterizer for x-major lines. A load request (req_type 0) orders the two
// endpoints so x rises and gives the start pixel as one result; each step request
// (req_type 1) moves one column east or diagonally and gives the new pixel, or its 3x3
// neighbourhood in outline mode, every result flagged in_grid against grid_max_col and
// grid_max_row (config index 0 and 1, reset 15). A step with no line loaded, or after the
// end column, gives nothing. The front end takes one request per cycle while the job
// queue (QUEUE_DEPTH entries) has room; the back end sends one pixel per cycle while
// the output is ready, so a load or plain step gives one pixel and an outline step nine.
// A first result is written to the queue, then to the output register, before it is valid.
module midpoint_line_rasterizer #(
	parameter int COORD_BITS  = 10,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	mlr_req_if.sink     req,
	mlr_pix_if.source   pix,
	mlr_cfg_if.sink     cfg
);
	import mlr_pkg::*;

	localparam int JOB_W = JOB_CTL_W + 2 * COORD_BITS;

	logic                  push_valid, q_full, q_not_empty, q_pop;
	logic [COORD_BITS-1:0] push_x, push_y, job_x, job_y;
	job_ctl_t              push_ctl, job_ctl;
	logic [JOB_W-1:0]      head_data;

	mlr_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.q_full     (q_full),
		.push_valid (push_valid),
		.push_x     (push_x),
		.push_y     (push_y),
		.push_ctl   (push_ctl)
	);

	mlr_queue #(.WIDTH(JOB_W), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push_valid),
		.push_data ({push_ctl, push_x, push_y}),
		.pop       (q_pop),
		.head_data (head_data),
		.not_empty (q_not_empty),
		.full      (q_full)
	);

	assign {job_ctl, job_x, job_y} = head_data;

	mlr_back #(.COORD_BITS(COORD_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.job_valid (q_not_empty),
		.job_x     (job_x),
		.job_y     (job_y),
		.job_ctl   (job_ctl),
		.job_pop   (q_pop),
		.pix       (pix)
	);

endmodule

### hw/rtl/mlr_front.sv
module mlr_front #(
	parameter int COORD_BITS = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	mlr_req_if.sink               req,
	input  logic                  q_full,
	output logic                  push_valid,
	output logic [COORD_BITS-1:0] push_x,
	output logic [COORD_BITS-1:0] push_y,
	output mlr_pkg::job_ctl_t     push_ctl
);
	import mlr_pkg::*;

	localparam int DW = COORD_BITS + 4;
	localparam int IW = COORD_BITS + 3;

	logic [COORD_BITS-1:0] cur_col_q, cur_row_q, end_col_q;
	logic signed [DW-1:0]  decision_q;
	logic signed [IW-1:0]  inc_straight_q, inc_diagonal_q;
	logic                  going_down_q, outline_mode_q, line_active_q;

	logic                  accept, is_load;
	logic [COORD_BITS-1:0] ax, ay, bx, by, dx, ady;
	logic                  ld_down, ld_done;
	logic signed [DW-1:0]  ld_decision;
	logic signed [IW-1:0]  ld_inc_s, ld_inc_d;
	logic signed [IW-1:0]  st_inc;
	logic signed [DW:0]    st_sum;
	logic signed [DW-1:0]  st_decision;
	logic [COORD_BITS-1:0] st_col, st_row;
	logic                  st_done;

	assign req.ready = !q_full;
	assign accept    = req.valid && req.ready;
	assign is_load   = (req.req_type == REQ_LOAD);

	// load: order endpoints so x rises
	always_comb begin
		if (req.first_x > req.second_x) begin
			ax = req.second_x;
			ay = req.second_y;
			bx = req.first_x;
			by = req.first_y;
		end else begin
			ax = req.first_x;
			ay = req.first_y;
			bx = req.second_x;
			by = req.second_y;
		end
		dx          = bx - ax;
		ld_down     = !(by > ay);
		ady         = ld_down ? (ay - by) : (by - ay);
		ld_decision = DW'({ady, 1'b0}) - DW'(dx);
		ld_inc_s    = IW'({ady, 1'b0});
		ld_inc_d    = IW'({ady, 1'b0}) - IW'({dx, 1'b0});
		ld_done     = (dx == '0);
	end

	// step: one column with saturating decision
	always_comb begin
		st_row = cur_row_q;
		if (decision_q <= 0) begin
			st_inc = inc_straight_q;
		end else begin
			st_inc = inc_diagonal_q;
			st_row = going_down_q ? (cur_row_q - 1'b1) : (cur_row_q + 1'b1);
		end
		st_sum = (DW+1)'(decision_q) + (DW+1)'(st_inc);
		if (st_sum[DW] != st_sum[DW-1]) begin
			st_decision = st_sum[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
		end else begin
			st_decision = st_sum[DW-1:0];
		end
		st_col  = cur_col_q + 1'b1;
		st_done = (st_col >= end_col_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q      <= '0;
			cur_row_q      <= '0;
			end_col_q      <= '0;
			decision_q     <= '0;
			inc_straight_q <= '0;
			inc_diagonal_q <= '0;
			going_down_q   <= 1'b0;
			outline_mode_q <= 1'b0;
			line_active_q  <= 1'b0;
		end else if (accept) begin
			if (is_load) begin
				cur_col_q      <= ax;
				cur_row_q      <= ay;
				end_col_q      <= bx;
				decision_q     <= ld_decision;
				inc_straight_q <= ld_inc_s;
				inc_diagonal_q <= ld_inc_d;
				going_down_q   <= ld_down;
				outline_mode_q <= req.outline;
				line_active_q  <= !ld_done;
			end else if (line_active_q) begin
				cur_col_q  <= st_col;
				cur_row_q  <= st_row;
				decision_q <= st_decision;
				if (st_done) begin
					line_active_q <= 1'b0;
				end
			end
		end
	end

	// a step with no line gives no job
	assign push_valid    = accept && (is_load || line_active_q);
	assign push_x        = is_load ? ax : st_col;
	assign push_y        = is_load ? ay : st_row;
	assign push_ctl.many = !is_load && outline_mode_q;
	assign push_ctl.done = is_load ? ld_done : st_done;

endmodule

### hw/rtl/mlr_queue.sv
module mlr_queue #(
	parameter int WIDTH = 22,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] head_data,
	output logic             not_empty,
	output logic             full
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### hw/rtl/mlr_back.sv
module mlr_back #(
	parameter int COORD_BITS = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	mlr_cfg_if.sink               cfg,
	input  logic                  job_valid,
	input  logic [COORD_BITS-1:0] job_x,
	input  logic [COORD_BITS-1:0] job_y,
	input  mlr_pkg::job_ctl_t     job_ctl,
	output logic                  job_pop,
	mlr_pix_if.source             pix
);
	import mlr_pkg::*;

	localparam int PW = COORD_BITS + 2;
	localparam int WW = (PW > PIX_W) ? PW : PIX_W;

	logic [CFG_W-1:0] grid_max_col_q, grid_max_row_q;
	logic [1:0]       di_q, dj_q;
	logic             pix_valid_q;
	logic signed [PIX_W-1:0] pix_x_q, pix_y_q;
	logic             in_grid_q, last_q, done_q;

	logic             advance, take, last;
	logic [1:0]       ei, ej;
	logic signed [PW-1:0] px, py;
	logic signed [WW-1:0] px_w, py_w;
	logic             in_box;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_max_col_q <= GRID_MAX_RESET;
			grid_max_row_q <= GRID_MAX_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_GRID_MAX_COL: grid_max_col_q <= cfg.data;
				CFG_GRID_MAX_ROW: grid_max_row_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign advance = !pix_valid_q || pix.ready;
	assign take    = advance && job_valid;
	assign last    = !job_ctl.many || (di_q == 2'd2 && dj_q == 2'd2);
	assign job_pop = take && last;

	// offset index 0..2 stands for -1..+1, plain pixels sit at the center
	always_comb begin
		ei     = job_ctl.many ? di_q : 2'd1;
		ej     = job_ctl.many ? dj_q : 2'd1;
		px     = PW'(job_x) + PW'(ei) - PW'(1);
		py     = PW'(job_y) + PW'(ej) - PW'(1);
		px_w   = WW'(px);
		py_w   = WW'(py);
		in_box = !px[PW-1] && !py[PW-1] &&
			($unsigned(px_w) <= WW'(grid_max_col_q)) &&
			($unsigned(py_w) <= WW'(grid_max_row_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid_q <= 1'b0;
			di_q        <= '0;
			dj_q        <= '0;
		end else if (advance) begin
			pix_valid_q <= job_valid;
			if (job_valid) begin
				if (last) begin
					di_q <= '0;
					dj_q <= '0;
				end else if (dj_q == 2'd2) begin
					di_q <= di_q + 1'b1;
					dj_q <= '0;
				end else begin
					dj_q <= dj_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pix_x_q   <= px_w[PIX_W-1:0];
			pix_y_q   <= py_w[PIX_W-1:0];
			in_grid_q <= in_box;
			last_q    <= last;
			done_q    <= job_ctl.done;
		end
	end

	assign pix.valid        = pix_valid_q;
	assign pix.pix_x        = pix_x_q;
	assign pix.pix_y        = pix_y_q;
	assign pix.in_grid      = in_grid_q;
	assign pix.last_of_item = last_q;
	assign pix.line_done    = done_q;

endmodule

### hw/rtl/mlr_checker.sv
module mlr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          valid,
	input logic                          ready,
	input logic signed [mlr_pkg::PIX_W-1:0] pix_x,
	input logic signed [mlr_pkg::PIX_W-1:0] pix_y,
	input logic                          in_grid,
	input logic                          last_of_item,
	input logic                          line_done
);
	import mlr_pkg::*;

	// a stalled result holds
	a_pix_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(pix_x) && $stable(pix_y) &&
			$stable(in_grid) && $stable(last_of_item) && $stable(line_done))
		else $error("result changed while stalled");

	// in_grid never marks a negative coordinate
	a_grid_sign: assert property (@(posedge clk) disable iff (!arst_n)
		valid && in_grid |-> !pix_x[PIX_W-1] && !pix_y[PIX_W-1])
		else $error("in_grid set on negative pixel");

	// all results of one request share line_done
	a_done_same: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && ready && !last_of_item) ##1 valid |-> line_done == $past(line_done))
		else $error("line_done changed inside one request");

	// neighbourhood pixels stay within one column of the previous one
	a_nbr_col: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && ready && !last_of_item) ##1 valid |->
			(pix_x == $past(pix_x)) || (pix_x == $past(pix_x) + 12'sd1))
		else $error("outline column jump");

endmodule

bind midpoint_line_rasterizer mlr_checker u_mlr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.valid        (pix.valid),
	.ready        (pix.ready),
	.pix_x        (pix.pix_x),
	.pix_y        (pix.pix_y),
	.in_grid      (pix.in_grid),
	.last_of_item (pix.last_of_item),
	.line_done    (pix.line_done)
);

### verif/midpoint_line_rasterizer_chk.sv
`timescale 1ns / 1ps
module midpoint_line_rasterizer_chk #(
	parameter int COORD_BITS = 10
) (
	input  logic clk,
	input  logic arst_n,
	mlr_req_if   req,
	mlr_pix_if   pix,
	mlr_cfg_if   cfg,
	output int   errors,
	output int   pending,
	output int   pixels_seen
);
	import mlr_pkg::*;

	localparam int DEC_W   = COORD_BITS + 4;
	localparam int INC_W   = COORD_BITS + 3;
	localparam int DEC_MAX = (1 << (COORD_BITS + 3)) - 1;
	localparam int DEC_MIN = -(1 << (COORD_BITS + 3));

	typedef struct packed {
		logic signed [PIX_W-1:0] x;
		logic signed [PIX_W-1:0] y;
		logic                    in_grid;
		logic                    last;
		logic                    done;
	} pixel_t;

	logic [CFG_W-1:0]        max_col;
	logic [CFG_W-1:0]        max_row;
	logic [COORD_BITS-1:0]   col;
	logic [COORD_BITS-1:0]   row;
	logic [COORD_BITS-1:0]   stop_col;
	logic signed [DEC_W-1:0] dec;
	logic signed [INC_W-1:0] inc_east;
	logic signed [INC_W-1:0] inc_diag;
	logic                    falling;
	logic                    outlined;
	logic                    active;
	pixel_t                  pixels_due[$];

	function automatic pixel_t make_pixel(input int x, input int y, input logic done,
		input logic last);
		pixel_t p;
		p.x       = x[PIX_W-1:0];
		p.y       = y[PIX_W-1:0];
		p.in_grid = x >= 0 && y >= 0 && x <= int'(max_col) && y <= int'(max_row);
		p.last    = last;
		p.done    = done;
		return p;
	endfunction

	task automatic rasterize_request(input logic kind, input int ax, input int ay,
		input int bx, input int by, input logic ol);
		int   x0, y0, x1, y1, dx, ady, sum;
		logic reached;
		x0 = ax;
		y0 = ay;
		x1 = bx;
		y1 = by;
		if (kind == REQ_LOAD) begin
			if (x0 > x1) begin
				x0 = bx;
				y0 = by;
				x1 = ax;
				y1 = ay;
			end
			dx       = x1 - x0;
			falling  = !(y1 > y0);
			ady      = falling ? y0 - y1 : y1 - y0;
			dec      = DEC_W'(2 * ady - dx);
			inc_east = INC_W'(2 * ady);
			inc_diag = INC_W'(2 * (ady - dx));
			outlined = ol;
			col      = x0[COORD_BITS-1:0];
			row      = y0[COORD_BITS-1:0];
			stop_col = x1[COORD_BITS-1:0];
			reached  = dx == 0;
			active   = !reached;
			pixels_due.push_back(make_pixel(x0, y0, reached, 1'b1));
		end else if (active) begin
			if (dec <= 0) begin
				sum = dec + inc_east;
			end else begin
				sum = dec + inc_diag;
				row = falling ? row - 1'b1 : row + 1'b1;
			end
			// steep lines run the decision into its rails
			if (sum > DEC_MAX) sum = DEC_MAX;
			if (sum < DEC_MIN) sum = DEC_MIN;
			dec     = sum[DEC_W-1:0];
			col     = col + 1'b1;
			reached = col >= stop_col;
			if (reached) active = 1'b0;
			if (outlined) begin
				for (int i = -1; i <= 1; i++)
					for (int j = -1; j <= 1; j++)
						pixels_due.push_back(make_pixel(int'(col) + i, int'(row) + j, reached,
							i == 1 && j == 1));
			end else begin
				pixels_due.push_back(make_pixel(int'(col), int'(row), reached, 1'b1));
			end
		end
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		pixel_t want;
		if (!arst_n) begin
			max_col  = GRID_MAX_RESET;
			max_row  = GRID_MAX_RESET;
			col      = '0;
			row      = '0;
			stop_col = '0;
			dec      = '0;
			inc_east = '0;
			inc_diag = '0;
			falling  = 1'b0;
			outlined = 1'b0;
			active   = 1'b0;
			pixels_due.delete();
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_GRID_MAX_COL: max_col = cfg.data;
					CFG_GRID_MAX_ROW: max_row = cfg.data;
					default: ;
				endcase
			end
			if (pix.valid && pix.ready) begin
				pixels_seen++;
				if (pixels_due.size() == 0) begin
					errors++;
					$display("%0t: pixel transfer with nothing expected, got x=%0d y=%0d",
						$time, pix.pix_x, pix.pix_y);
				end else begin
					want = pixels_due.pop_front();
					check_field("pix_x", want.x, pix.pix_x);
					check_field("pix_y", want.y, pix.pix_y);
					check_field("in_grid", want.in_grid, pix.in_grid);
					check_field("last_of_item", want.last, pix.last_of_item);
					check_field("line_done", want.done, pix.line_done);
				end
			end
			if (req.valid && req.ready)
				rasterize_request(req.req_type, int'(req.first_x), int'(req.first_y),
					int'(req.second_x), int'(req.second_y), req.outline);
		end
		pending = pixels_due.size();
	end

endmodule

### verif/midpoint_line_rasterizer_tb.sv
`timescale 1ns / 1ps
module midpoint_line_rasterizer_tb;
	import mlr_pkg::*;

	localparam int COORD_BITS    = 10;
	localparam int COORD_TOP     = (1 << COORD_BITS) - 1;
	localparam int IDLE_PCT      = 22;
	localparam int HOLD_CYCLES   = 80;
	localparam int SETTLE_CYCLES = 20;
	localparam int QUIET_LIMIT   = 2000;
	localparam int PHASE_ITEMS   = 42;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	mlr_req_if #(.COORD_BITS(COORD_BITS)) req();
	mlr_pix_if pix();
	mlr_cfg_if cfg();

	int errors;
	int pending;
	int pixels_seen;
	int quiet;
	int hold_asks;
	int holds_done;
	int loads;
	int steps;
	int outline_lines;
	int work_items;
	bit steady;

	midpoint_line_rasterizer #(.COORD_BITS(COORD_BITS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.pix    (pix),
		.cfg    (cfg)
	);

	midpoint_line_rasterizer_chk #(.COORD_BITS(COORD_BITS)) chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.pix         (pix),
		.cfg         (cfg),
		.errors      (errors),
		.pending     (pending),
		.pixels_seen (pixels_seen)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (pix.valid && pix.ready) || (cfg.valid && cfg.ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("%0t: watchdog, no transfer for %0d cycles", $time, quiet);
			$display("Regression FAIL");
			$finish;
		end
	end

	// pixel sink: random back-pressure, plus long hold-offs on request
	initial begin
		forever begin
			if (hold_asks != holds_done) begin
				pix.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				holds_done++;
			end else begin
				pix.ready <= steady || $urandom_range(99) >= IDLE_PCT;
				@(posedge clk);
			end
		end
	end

	function automatic int clip_coord(input int v);
		if (v < 0) return 0;
		if (v > COORD_TOP) return COORD_TOP;
		return v;
	endfunction

	function automatic int pick_coord();
		case ($urandom_range(0, 3))
			0, 1:    return $urandom_range(0, 20);
			2:       return $urandom_range(COORD_TOP - 20, COORD_TOP);
			default: return $urandom_range(0, COORD_TOP);
		endcase
	endfunction

	task automatic send_req(input logic kind, input int ax, input int ay, input int bx,
		input int by, input logic ol);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid    <= 1'b1;
		req.req_type <= kind;
		req.first_x  <= ax[COORD_BITS-1:0];
		req.first_y  <= ay[COORD_BITS-1:0];
		req.second_x <= bx[COORD_BITS-1:0];
		req.second_y <= by[COORD_BITS-1:0];
		req.outline  <= ol;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		if (kind == REQ_LOAD) loads++;
		else steps++;
	endtask

	task automatic send_stray_step();
		send_req(REQ_STEP, pick_coord(), pick_coord(), pick_coord(), pick_coord(),
			1'($urandom_range(0, 1)));
	endtask

	// stop offering and wait out every expected pixel
	task automatic drain_results();
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_grid(input logic [CFG_W-1:0] max_col, input logic [CFG_W-1:0] max_row);
		cfg.valid <= 1'b1;
		cfg.index <= CFG_GRID_MAX_COL;
		cfg.data  <= max_col;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.index <= CFG_GRID_MAX_ROW;
		cfg.data  <= max_row;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic random_line();
		int   x0, y0, x1, y1, span, dx, runs;
		logic ol;
		x0   = pick_coord();
		y0   = pick_coord();
		span = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 40))
			: int'($urandom_range(0, 10));
		x1   = clip_coord($urandom_range(0, 1) ? x0 + span : x0 - span);
		y1   = $urandom_range(0, 1) ? pick_coord()
			: clip_coord(y0 + int'($urandom_range(0, 10)) - 5);
		ol   = $urandom_range(0, 2) == 0;
		send_req(REQ_LOAD, x0, y0, x1, y1, ol);
		work_items++;
		if (ol) outline_lines++;
		dx   = (x1 > x0) ? x1 - x0 : x0 - x1;
		runs = dx + int'($urandom_range(0, 1));
		for (int k = 0; k < runs; k++) begin
			// now and then the next load cuts the line short
			if ($urandom_range(0, 24) == 0) break;
			send_stray_step();
			if (k < dx) work_items++;
		end
	endtask

	initial begin
		logic [CFG_W-1:0] grid_cols[4];
		logic [CFG_W-1:0] grid_rows[4];
		int               target;
		bit               paused;
		req.valid    <= 1'b0;
		req.req_type <= REQ_LOAD;
		req.first_x  <= '0;
		req.first_y  <= '0;
		req.second_x <= '0;
		req.second_y <= '0;
		req.outline  <= 1'b0;
		cfg.valid    <= 1'b0;
		cfg.index    <= CFG_GRID_MAX_COL;
		cfg.data     <= '0;
		grid_cols    = '{CFG_W'(0), CFG_W'(COORD_TOP), CFG_W'($urandom_range(0, COORD_TOP)),
			CFG_W'(COORD_TOP)};
		grid_rows    = '{CFG_W'(0), CFG_W'(COORD_TOP), CFG_W'($urandom_range(0, COORD_TOP)),
			CFG_W'(0)};
		paused       = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, grid at its reset size
		send_req(REQ_STEP, COORD_TOP, COORD_TOP, COORD_TOP, COORD_TOP, 1'b1);  // nothing loaded
		send_req(REQ_LOAD, 0, 0, 0, 0, 1'b1);                                  // zero length
		send_req(REQ_STEP, 0, 0, 0, 0, 1'b0);                                  // past the end
		send_req(REQ_LOAD, 5, 3, 5, 9, 1'b0);                                  // equal columns
		// swapped endpoints, outline crosses the top edge of the coordinate range
		send_req(REQ_LOAD, COORD_TOP, COORD_TOP, COORD_TOP - 3, COORD_TOP, 1'b1);
		repeat (3) send_req(REQ_STEP, 0, 0, 0, 0, 1'b0);
		// flat along row 0, outline reaches row -1, then reloaded mid-line
		send_req(REQ_LOAD, 0, 0, 5, 0, 1'b1);
		repeat (2) send_req(REQ_STEP, 0, 0, 0, 0, 1'b1);
		// steep rising line, decision saturates
		send_req(REQ_LOAD, 0, 0, 6, COORD_TOP, 1'b0);
		repeat (6) send_req(REQ_STEP, 0, 0, 0, 0, 1'b0);
		// steep falling line after a swap, dropped by the next load
		send_req(REQ_LOAD, COORD_TOP, 0, COORD_TOP - 10, COORD_TOP, 1'b0);
		repeat (3) send_req(REQ_STEP, 0, 0, 0, 0, 1'b0);
		send_req(REQ_LOAD, 2, 10, 12, 6, 1'b0);
		repeat (2) send_req(REQ_STEP, 0, 0, 0, 0, 1'b0);
		outline_lines += 3;

		for (int phase = 0; phase < 4; phase++) begin
			drain_results();
			write_grid(grid_cols[phase], grid_rows[phase]);
			steady = phase == 2;
			target = work_items + PHASE_ITEMS;
			if (phase == 1) begin
				// sink holds off while outline steps pile up behind it
				hold_asks++;
				send_req(REQ_LOAD, 100, 200, 108, 205, 1'b1);
				repeat (8) send_req(REQ_STEP, 0, 0, 0, 0, 1'b0);
				outline_lines++;
				work_items += 9;
			end
			while (work_items < target) begin
				if ($urandom_range(0, 7) == 0) send_stray_step();
				else random_line();
				if (phase == 0 && !paused && work_items >= target - PHASE_ITEMS / 2) begin
					drain_results();
					paused = 1'b1;
				end
			end
		end
		steady = 1'b0;
		drain_results();

		$display("Covered %0d loads and %0d steps (%0d outline lines), %0d pixels checked,",
			loads, steps, outline_lines, pixels_seen);
		$display("across the reset grid and four more grid sizes, zero and full among them");
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
